// ===== rtl/wmms_pkg.sv =====
// ----------------------------------------------------------------------------
// wmms_pkg
// Shared types, constants and helpers for the weight matrix motif scan unit.
// ----------------------------------------------------------------------------
package wmms_pkg;

  localparam int MAX_MOTIF_LEN = 32;
  localparam int WEIGHT_BITS   = 16;
  localparam int POSITION_BITS = 32;

  localparam int IDX_BITS   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
  localparam int CODE_BITS  = 3;
  localparam int ROW_BITS   = 2;
  localparam int ROWS       = 4;
  localparam int SCORE_BITS = 24;
  localparam int ACC_BITS   = WEIGHT_BITS + IDX_BITS + 1;
  localparam int SAT_BITS   = ACC_BITS + SCORE_BITS;
  localparam int LEN_FIELD_BITS = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int HIT_BITS       = 32;
  localparam int IN_WEIGHT_BITS = 16;

  localparam logic [CODE_BITS-1:0] CODE_N = 3'd4;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SKIP_N     = 3'd1,
    REG_MOTIF_LEN  = 3'd2,
    REG_RANGE_FROM = 3'd3,
    REG_RANGE_TO   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TERM,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load_term;
    logic skip_n;
  } cell_ctl_t;

  typedef struct packed {
    logic                          en;
    logic [ROW_BITS-1:0]           row;
    logic signed [WEIGHT_BITS-1:0] value;
  } wt_wr_t;

  function automatic logic signed [SCORE_BITS-1:0] sat_score(
    input logic signed [ACC_BITS-1:0] s
  );
    logic signed [SAT_BITS-1:0] w;
    logic signed [SAT_BITS-1:0] hi;
    logic signed [SAT_BITS-1:0] lo;
    logic signed [SCORE_BITS-1:0] r;
    w  = SAT_BITS'(s);
    hi = SAT_BITS'({1'b0, {(SCORE_BITS-1){1'b1}}});
    lo = -hi - SAT_BITS'(1);
    if (w > hi) begin
      r = hi[SCORE_BITS-1:0];
    end else if (w < lo) begin
      r = lo[SCORE_BITS-1:0];
    end else begin
      r = w[SCORE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/weight_matrix_motif_scan_unit.sv =====
// ----------------------------------------------------------------------------
// weight_matrix_motif_scan_unit
// Position weight matrix scanner over a stream of coded DNA bases.
// ----------------------------------------------------------------------------
// A load item writes one weight. A base item passes through these steps: the
// base shifts into the window, each column looks up its weight, the partial
// score ripples through the chain of column cells, and the hit is compared
// and posted. No new item is taken while a base is in work. A hit waits in
// the output register, and the block stalls at its end only if the previous
// hit is still not taken.
module weight_matrix_motif_scan_unit (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [wmms_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [wmms_pkg::CFG_DATA_BITS-1:0]         cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       op,
  input  logic [2:0]                                 base_code,
  input  logic                                       first_base,
  input  logic [4:0]                                 weight_position,
  input  logic [1:0]                                 weight_base,
  input  logic signed [wmms_pkg::IN_WEIGHT_BITS-1:0] weight_value,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [wmms_pkg::HIT_BITS-1:0]              hit_start,
  output logic [wmms_pkg::HIT_BITS-1:0]              hit_end,
  output logic signed [wmms_pkg::SCORE_BITS-1:0]     hit_score
);

  localparam int N = wmms_pkg::MAX_MOTIF_LEN;

  // configuration
  logic signed [wmms_pkg::SCORE_BITS-1:0] score_threshold;
  logic                                   skip_n_mode;
  logic [wmms_pkg::IDX_BITS-1:0]          len_m1;
  logic [wmms_pkg::CFG_DATA_BITS-1:0]     range_from;
  logic [wmms_pkg::CFG_DATA_BITS-1:0]     range_to;
  logic [wmms_pkg::LEN_FIELD_BITS-1:0]    len_field;

  assign cfg_ready = 1'b1;
  assign len_field = cfg_data[wmms_pkg::LEN_FIELD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= {1'b1, {(wmms_pkg::SCORE_BITS-1){1'b0}}};
      skip_n_mode     <= 1'b1;
      len_m1          <= '0;
      range_from      <= '0;
      range_to        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmms_pkg::REG_THRESHOLD:  score_threshold <= cfg_data[wmms_pkg::SCORE_BITS-1:0];
        wmms_pkg::REG_SKIP_N:     skip_n_mode     <= cfg_data[0];
        wmms_pkg::REG_MOTIF_LEN: begin
          if (len_field == '0) begin
            len_m1 <= '0;
          end else if (32'(len_field) > 32'(N)) begin
            len_m1 <= wmms_pkg::IDX_BITS'(N - 1);
          end else begin
            len_m1 <= wmms_pkg::IDX_BITS'(len_field - 1'b1);
          end
        end
        wmms_pkg::REG_RANGE_FROM: range_from <= cfg_data;
        wmms_pkg::REG_RANGE_TO:   range_to   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  wmms_pkg::state_t              state;
  wmms_pkg::state_t              state_next;
  logic [wmms_pkg::IDX_BITS-1:0] run_cnt;
  logic                          in_xfer;
  logic                          base_xfer;
  logic                          load_xfer;
  logic                          out_free;
  logic                          hit;
  logic                          post_hit;
  wmms_pkg::cell_ctl_t           ctl;

  assign in_stall  = (state != wmms_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign base_xfer = in_xfer && (op == wmms_pkg::OP_BASE);
  assign load_xfer = in_xfer && (op == wmms_pkg::OP_LOAD);
  assign out_free  = !out_valid || !out_stall;

  // position count and window bookkeeping
  logic [wmms_pkg::POSITION_BITS-1:0] cnt;
  logic [wmms_pkg::POSITION_BITS-1:0] cnt0;
  logic [wmms_pkg::POSITION_BITS-1:0] cnt1;
  logic [wmms_pkg::POSITION_BITS-1:0] len_pos;
  logic [wmms_pkg::POSITION_BITS-1:0] start0;
  logic                               win_ok;
  logic                               pend_ok;
  logic [wmms_pkg::HIT_BITS-1:0]      pend_start;
  logic [wmms_pkg::HIT_BITS-1:0]      pend_end;

  always_comb begin
    cnt0    = first_base ? '0 : cnt;
    cnt1    = cnt0 + 1'b1;
    len_pos = wmms_pkg::POSITION_BITS'(len_m1) + 1'b1;
    start0  = cnt1 - len_pos;
    win_ok  = (cnt0 != wmms_pkg::POS_MAX) && (cnt1 != wmms_pkg::POS_MAX)
              && (cnt1 >= len_pos) && (start0 >= range_from)
              && ((range_to == '0) || (cnt1 <= range_to));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (base_xfer) begin
      cnt <= (cnt0 == wmms_pkg::POS_MAX) ? cnt0 : cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (base_xfer) begin
      pend_ok    <= win_ok;
      pend_start <= wmms_pkg::HIT_BITS'(start0 + 1'b1);
      pend_end   <= wmms_pkg::HIT_BITS'(cnt1 + 1'b1);
    end
  end

  // chain of column cells
  logic [wmms_pkg::CODE_BITS-1:0]       hist     [N];
  logic [wmms_pkg::CODE_BITS-1:0]       hist_in  [N];
  logic signed [wmms_pkg::ACC_BITS-1:0] sum      [N];
  logic signed [wmms_pkg::ACC_BITS-1:0] sum_in   [N];
  logic                                 bad      [N];
  logic                                 bad_in   [N];
  logic signed [wmms_pkg::ACC_BITS-1:0] score_sum;
  logic                                 score_bad;
  logic signed [wmms_pkg::SCORE_BITS-1:0] score;

  for (genvar p = 0; p < N; p++) begin : g_cell
    wmms_pkg::wt_wr_t              wr;
    logic [wmms_pkg::IDX_BITS-1:0] src;

    assign src      = len_m1 - wmms_pkg::IDX_BITS'(p);
    assign wr.en    = load_xfer && (32'(weight_position) == 32'(p));
    assign wr.row   = weight_base;
    assign wr.value = wmms_pkg::WEIGHT_BITS'(weight_value);

    if (p == 0) begin : g_head
      assign hist_in[p] = base_code;
      assign sum_in[p]  = '0;
      assign bad_in[p]  = 1'b0;
    end else begin : g_link
      assign hist_in[p] = hist[p-1];
      assign sum_in[p]  = sum[p-1];
      assign bad_in[p]  = bad[p-1];
    end

    wmms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr       (wr),
      .active   (wmms_pkg::IDX_BITS'(p) <= len_m1),
      .hist_in  (hist_in[p]),
      .hist_out (hist[p]),
      .sel_code (hist[src]),
      .sum_in   (sum_in[p]),
      .bad_in   (bad_in[p]),
      .sum_out  (sum[p]),
      .bad_out  (bad[p])
    );
  end

  assign score_sum = sum[len_m1];
  assign score_bad = bad[len_m1];
  assign score     = wmms_pkg::sat_score(score_sum);
  assign hit       = pend_ok && !score_bad && (score >= score_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wmms_pkg::ST_TERM) begin
      run_cnt <= len_m1;
    end else if (state == wmms_pkg::ST_SUM) begin
      run_cnt <= run_cnt - 1'b1;
    end
  end

  always_comb begin
    state_next    = state;
    post_hit      = 1'b0;
    ctl.shift     = base_xfer;
    ctl.load_term = 1'b0;
    ctl.skip_n    = skip_n_mode;
    case (state)
      wmms_pkg::ST_IDLE: begin
        if (base_xfer) begin
          state_next = wmms_pkg::ST_TERM;
        end
      end
      wmms_pkg::ST_TERM: begin
        ctl.load_term = 1'b1;
        state_next    = wmms_pkg::ST_SUM;
      end
      wmms_pkg::ST_SUM: begin
        if (run_cnt == '0) begin
          state_next = wmms_pkg::ST_DONE;
        end
      end
      wmms_pkg::ST_DONE: begin
        if (!hit) begin
          state_next = wmms_pkg::ST_IDLE;
        end else if (out_free) begin
          post_hit   = 1'b1;
          state_next = wmms_pkg::ST_IDLE;
        end
      end
      default: state_next = wmms_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_hit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_hit) begin
      hit_start <= pend_start;
      hit_end   <= pend_end;
      hit_score <= score;
    end
  end

endmodule

// ===== rtl/wmms_cell.sv =====
// ----------------------------------------------------------------------------
// wmms_cell
// One matrix column: holds one window base, four weights, and one stage of
// the running score that passes from cell to cell.
// ----------------------------------------------------------------------------
module wmms_cell (
  input  logic                                    clk,
  input  logic                                    rst,
  input  wmms_pkg::cell_ctl_t                     ctl,
  input  wmms_pkg::wt_wr_t                        wr,
  input  logic                                    active,
  input  logic [wmms_pkg::CODE_BITS-1:0]          hist_in,
  output logic [wmms_pkg::CODE_BITS-1:0]          hist_out,
  input  logic [wmms_pkg::CODE_BITS-1:0]          sel_code,
  input  logic signed [wmms_pkg::ACC_BITS-1:0]    sum_in,
  input  logic                                    bad_in,
  output logic signed [wmms_pkg::ACC_BITS-1:0]    sum_out,
  output logic                                    bad_out
);

  logic [wmms_pkg::CODE_BITS-1:0]          hist;
  logic signed [wmms_pkg::WEIGHT_BITS-1:0] weight [wmms_pkg::ROWS];
  logic signed [wmms_pkg::WEIGHT_BITS-1:0] term;
  logic                                    bad;
  logic signed [wmms_pkg::ACC_BITS-1:0]    sum;
  logic                                    bad_acc;
  logic                                    is_acgt;
  logic                                    is_bad;

  always_comb begin
    is_acgt = sel_code < wmms_pkg::CODE_N;
    is_bad  = (sel_code > wmms_pkg::CODE_N) || ((sel_code == wmms_pkg::CODE_N) && ctl.skip_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctl.shift) begin
      hist <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      weight[wr.row] <= wr.value;
    end
  end

  // term and flag of this column for the current window
  always_ff @(posedge clk) begin
    if (ctl.load_term) begin
      term <= (active && is_acgt) ? weight[sel_code[wmms_pkg::ROW_BITS-1:0]] : '0;
      bad  <= active && is_bad;
    end
  end

  // score stage, settles one cell further each cycle
  always_ff @(posedge clk) begin
    sum     <= sum_in + wmms_pkg::ACC_BITS'(term);
    bad_acc <= bad_in | bad;
  end

  assign hist_out = hist;
  assign sum_out  = sum;
  assign bad_out  = bad_acc;

endmodule

// ===== rtl/wmms_checker.sv =====
// ----------------------------------------------------------------------------
// wmms_checker
// Port level checks for the weight matrix motif scan unit.
// ----------------------------------------------------------------------------
module wmms_checker (
  input logic                                       clk,
  input logic                                       rst,
  input logic                                       in_valid,
  input logic                                       in_stall,
  input logic                                       op,
  input logic                                       out_valid,
  input logic                                       out_stall,
  input logic [wmms_pkg::HIT_BITS-1:0]              hit_start,
  input logic [wmms_pkg::HIT_BITS-1:0]              hit_end,
  input logic signed [wmms_pkg::SCORE_BITS-1:0]     hit_score
);

  // a stalled hit holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit_start) && $stable(hit_end)
                               && $stable(hit_score))
    else $error("stalled hit changed");

  // a base transfer always starts scoring work
  a_base_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == wmms_pkg::OP_BASE) |=> in_stall)
    else $error("no busy cycle after base transfer");

  // a weight load never occupies the block
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == wmms_pkg::OP_LOAD) |=> !in_stall)
    else $error("stall after weight load");

  // window end lies one to max motif length past its start
  a_hit_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_end > hit_start)
                  && ((hit_end - hit_start) <= wmms_pkg::HIT_BITS'(wmms_pkg::MAX_MOTIF_LEN)))
    else $error("hit span out of range");

endmodule

bind weight_matrix_motif_scan_unit wmms_checker u_wmms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit_start (hit_start),
  .hit_end   (hit_end),
  .hit_score (hit_score)
);
